// ----- src/llr_pkg.sv -----
// shared types, codes and defaults for the line-loss recovery sequencer
`timescale 1ns / 1ps

package llr_pkg;

    // default counter width
    localparam int COUNTER_WIDTH_DEF = 16;

    // configuration register width and index width
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS   = 3'd4;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_LOST_THRESHOLD = 16'd5;
    localparam logic [CFG_W-1:0] RST_LOST_LIMIT     = 16'd255;
    localparam logic [CFG_W-1:0] RST_BRAKE_TICKS    = 16'd100;
    localparam logic [CFG_W-1:0] RST_RECOVER_TICKS  = 16'd5;
    localparam logic [CFG_W-1:0] RST_STABLE_TICKS   = 16'd200;

    // request types
    localparam logic [1:0] REQ_POLL    = 2'd0;
    localparam logic [1:0] REQ_DIR     = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // request codes reported with each result
    localparam logic [1:0] RQ_NONE  = 2'd0;
    localparam logic [1:0] RQ_RIGHT = 2'd1;
    localparam logic [1:0] RQ_LEFT  = 2'd2;
    localparam logic [1:0] RQ_FOUND = 2'd3;

    // phase codes reported with each result
    localparam logic [2:0] PH_NORMAL  = 3'd0;
    localparam logic [2:0] PH_BRAKE   = 3'd1;
    localparam logic [2:0] PH_ROTATE  = 3'd2;
    localparam logic [2:0] PH_RECOVER = 3'd3;
    localparam logic [2:0] PH_STABLE  = 3'd4;

    // stored steering direction codes
    localparam logic [1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [1:0] DIR_RIGHT   = 2'd1;
    localparam logic [1:0] DIR_LEFT    = 2'd3;

    // configuration register set
    typedef struct packed {
        logic [CFG_W-1:0] lost_threshold;
        logic [CFG_W-1:0] lost_limit;
        logic [CFG_W-1:0] brake_ticks;
        logic [CFG_W-1:0] recover_ticks;
        logic [CFG_W-1:0] stable_ticks;
    } t_cfg;

    // one registered input item, sensor byte already reduced to line seen
    typedef struct packed {
        logic [1:0] req_type;
        logic       traj_busy;
        logic       line;
        logic [1:0] corr_sign;
    } t_item;

    // one result item
    typedef struct packed {
        logic [1:0] request_code;
        logic [2:0] phase;
        logic       pid_reset;
    } t_result;

endpackage

// ----- src/llr_cfg.sv -----
// configuration register file of the line-loss recovery sequencer
`timescale 1ns / 1ps

module llr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [llr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [llr_pkg::CFG_W-1:0]      i_cfg_wdata,
    output llr_pkg::t_cfg                  o_cfg
);
    import llr_pkg::*;

    t_cfg r_cfg;

    // register writes, writes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lost_threshold <= RST_LOST_THRESHOLD;
            r_cfg.lost_limit     <= RST_LOST_LIMIT;
            r_cfg.brake_ticks    <= RST_BRAKE_TICKS;
            r_cfg.recover_ticks  <= RST_RECOVER_TICKS;
            r_cfg.stable_ticks   <= RST_STABLE_TICKS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOST_THRESHOLD: r_cfg.lost_threshold <= i_cfg_wdata;
                CFG_LOST_LIMIT:     r_cfg.lost_limit     <= i_cfg_wdata;
                CFG_BRAKE_TICKS:    r_cfg.brake_ticks    <= i_cfg_wdata;
                CFG_RECOVER_TICKS:  r_cfg.recover_ticks  <= i_cfg_wdata;
                CFG_STABLE_TICKS:   r_cfg.stable_ticks   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/llr_seq.sv -----
// recovery phase sequencer: state registers and one-step next-state logic
`timescale 1ns / 1ps

module llr_seq #(
    parameter int COUNTER_WIDTH = llr_pkg::COUNTER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  llr_pkg::t_item   i_item,
    input  llr_pkg::t_cfg    i_cfg,
    output llr_pkg::t_result o_result
);
    import llr_pkg::*;

    localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        ST_FOLLOW  = PH_NORMAL,
        ST_BRAKE   = PH_BRAKE,
        ST_SPIN    = PH_ROTATE,
        ST_CONFIRM = PH_RECOVER,
        ST_SETTLE  = PH_STABLE
    } t_phase;

    t_phase                   r_phase,   n_phase;
    logic [COUNTER_WIDTH-1:0] r_lost,    n_lost;
    logic [COUNTER_WIDTH-1:0] r_confirm, n_confirm;
    logic [COUNTER_WIDTH-1:0] r_brake,   n_brake;
    logic [COUNTER_WIDTH-1:0] r_settle,  n_settle;
    logic [1:0]               r_dir,     n_dir;
    logic [1:0]               r_request, n_request;
    logic                     pulse;

    // next state for the item at the head of the pipe
    always_comb begin
        logic [1:0]               rot_req;
        logic [COUNTER_WIDTH-1:0] lost_step;
        logic [COUNTER_WIDTH-1:0] confirm_step;

        rot_req      = (r_dir == DIR_LEFT) ? RQ_LEFT : RQ_RIGHT;
        lost_step    = r_lost;
        confirm_step = r_confirm;

        n_phase   = r_phase;
        n_lost    = r_lost;
        n_confirm = r_confirm;
        n_brake   = r_brake;
        n_settle  = r_settle;
        n_dir     = r_dir;
        n_request = r_request;
        pulse     = 1'b0;

        case (i_item.req_type)
            REQ_POLL: begin
                if (!i_item.traj_busy) begin
                    n_request = RQ_NONE;
                end else begin
                    // saturating lost tick counter
                    if (i_item.line) begin
                        lost_step = '0;
                    end else if ((CMP_W'(r_lost) < CMP_W'(i_cfg.lost_limit))
                                 && (r_lost != CNT_MAX)) begin
                        lost_step = r_lost + CNT_ONE;
                    end
                    n_lost = lost_step;

                    case (r_phase)
                        ST_FOLLOW: begin
                            if (CMP_W'(lost_step) >= CMP_W'(i_cfg.lost_threshold)) begin
                                n_request = rot_req;
                                n_brake   = COUNTER_WIDTH'(i_cfg.brake_ticks);
                                n_phase   = ST_BRAKE;
                            end
                        end
                        ST_BRAKE: begin
                            if (r_brake != '0) begin
                                n_brake = r_brake - CNT_ONE;
                            end else begin
                                n_request = rot_req;
                                n_phase   = ST_SPIN;
                            end
                        end
                        ST_SPIN: begin
                            if (i_item.line) begin
                                n_request = RQ_FOUND;
                                n_confirm = CNT_ONE;
                                n_phase   = ST_CONFIRM;
                            end
                        end
                        ST_CONFIRM: begin
                            if (i_item.line) begin
                                if (r_confirm != CNT_MAX) begin
                                    confirm_step = r_confirm + CNT_ONE;
                                end
                                n_confirm = confirm_step;
                                if (CMP_W'(confirm_step) >= CMP_W'(i_cfg.recover_ticks)) begin
                                    pulse     = 1'b1;
                                    n_request = RQ_NONE;
                                    n_settle  = COUNTER_WIDTH'(i_cfg.stable_ticks);
                                    n_phase   = ST_SETTLE;
                                end
                            end else begin
                                n_confirm = '0;
                                n_request = rot_req;
                                n_phase   = ST_SPIN;
                            end
                        end
                        ST_SETTLE: begin
                            if (r_settle != '0) begin
                                n_settle = r_settle - CNT_ONE;
                            end else begin
                                n_request = RQ_NONE;
                                n_lost    = '0;
                                n_confirm = '0;
                                n_phase   = ST_FOLLOW;
                            end
                        end
                        default: begin
                            n_phase = ST_FOLLOW;
                        end
                    endcase
                end
            end
            REQ_DIR: begin
                // any negative sign is left, zero keeps the old direction
                if (i_item.corr_sign[1]) begin
                    n_dir = DIR_LEFT;
                end else if (i_item.corr_sign[0]) begin
                    n_dir = DIR_RIGHT;
                end
            end
            REQ_RESTART: begin
                n_lost    = '0;
                n_confirm = '0;
                n_phase   = ST_FOLLOW;
                n_request = RQ_NONE;
                pulse     = 1'b1;
            end
            default: ;
        endcase
    end

    // state update when the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ST_FOLLOW;
            r_lost    <= '0;
            r_confirm <= '0;
            r_brake   <= '0;
            r_settle  <= '0;
            r_dir     <= DIR_UNKNOWN;
            r_request <= RQ_NONE;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_lost    <= n_lost;
            r_confirm <= n_confirm;
            r_brake   <= n_brake;
            r_settle  <= n_settle;
            r_dir     <= n_dir;
            r_request <= n_request;
        end
    end

    // result reflects the state after this item
    assign o_result.request_code = n_request;
    assign o_result.phase        = n_phase;
    assign o_result.pid_reset    = pulse;

endmodule

// ----- src/line_loss_recovery_fsm_unit.sv -----
// Line-loss recovery sequencer, top level with input and result registers.
// An item waits in the input register until the result register is free or being emptied.
// Throughput: one item per cycle without stalls; phase update is one sequencer step.
// Reset: synchronous, active low; clears phase, counters, direction and request,
// and loads configuration defaults. No clearing pass; items are taken right after reset.
`timescale 1ns / 1ps

module line_loss_recovery_fsm_unit #(
    parameter int COUNTER_WIDTH = llr_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [llr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [llr_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input item channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_req_type,
    input  logic                           i_traj_busy,
    input  logic [7:0]                     i_sensor_bits,
    input  logic signed [1:0]              i_corr_sign,
    // result item channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_request_code,
    output logic [2:0]                     o_phase,
    output logic                           o_pid_reset
);
    import llr_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    t_result seq_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    adv;
    logic    in_take;

    // item moves on when the result register is free or being emptied
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;
    assign in_take = i_valid && o_ready;

    llr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.req_type  <= i_req_type;
            r_item.traj_busy <= i_traj_busy;
            r_item.line      <= |i_sensor_bits;
            r_item.corr_sign <= i_corr_sign;
        end
    end

    llr_seq #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (seq_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= seq_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_request_code = r_result.request_code;
    assign o_phase        = r_result.phase;
    assign o_pid_reset    = r_result.pid_reset;

`ifndef SYNTHESIS
    // controller reset only on restart or on confirmed recovery
    a_pulse_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pid_reset) |-> (o_phase == PH_STABLE || o_phase == PH_NORMAL))
        else $error("pid reset outside normal or stable phase");

    // line found is only reported while confirming
    a_found_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_request_code == RQ_FOUND) |-> (o_phase == PH_RECOVER))
        else $error("line found reported outside recover phase");

    // rotate requests only while braking or rotating
    a_rotate_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_request_code == RQ_LEFT || o_request_code == RQ_RIGHT))
        |-> (o_phase == PH_BRAKE || o_phase == PH_ROTATE))
        else $error("rotate request outside brake or rotate phase");

    // a held input item is not dropped while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("input item lost while stalled");
`endif

endmodule

// ----- verif/tb_line_loss_recovery_fsm_unit.sv -----
// self-checking testbench for the line-loss recovery sequencer top level
`timescale 1ns / 1ps

module tb_line_loss_recovery_fsm_unit;
    import llr_pkg::*;

    localparam int CW = COUNTER_WIDTH_DEF;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam int DUT_LATENCY = 2;
    localparam int STALL_LIMIT = 1000;
    localparam int NUM_SETTINGS = 12;
    localparam int ITEMS_PER_SETTING = 150;
    localparam int SHORT_CFG_ROW = 15;

    // request type with no meaning, and correction sign patterns
    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam logic [1:0] SIGN_KEEP     = 2'b00;
    localparam logic [1:0] SIGN_RIGHT    = 2'b01;
    localparam logic [1:0] SIGN_NEG_TWO  = 2'b10;
    localparam logic [1:0] SIGN_LEFT     = 2'b11;

    // one input item, with an optional hand-written expectation
    typedef struct packed {
        logic [1:0] req;
        logic       traj;
        logic [7:0] sensor;
        logic [1:0] sign;
        logic       typed;
        t_result    exp;
    } t_stim;

    // settings for the walk down to stable and back
    localparam t_cfg SHORT_CFG = '{16'd1, 16'd3, 16'd1, 16'd2, 16'd1};

    // directed rows: default settings first, then the short settings
    localparam t_stim DIRECTED_ROWS [0:25] = '{
        '{REQ_POLL,    1'b0, 8'h00, SIGN_KEEP,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_DIR,     1'b0, 8'h00, SIGN_LEFT,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_DIR,     1'b1, 8'hFF, SIGN_NEG_TWO, 1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_DIR,     1'b0, 8'h00, SIGN_KEEP,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_DIR,     1'b1, 8'h55, SIGN_RIGHT,   1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_UNUSED,  1'b1, 8'hFF, SIGN_LEFT,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_RESTART, 1'b1, 8'hAA, SIGN_KEEP,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b1}},
        '{REQ_POLL,    1'b1, 8'hFF, SIGN_KEEP,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_LEFT,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b0}},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b1, '{RQ_RIGHT, PH_BRAKE,  1'b0}},
        '{REQ_POLL,    1'b1, 8'h80, SIGN_KEEP,    1'b0, '0},
        '{REQ_RESTART, 1'b0, 8'h00, SIGN_LEFT,    1'b1, '{RQ_NONE,  PH_NORMAL, 1'b1}},
        '{REQ_DIR,     1'b0, 8'h00, SIGN_LEFT,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'h01, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'h02, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'hFF, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b1, 8'h00, SIGN_KEEP,    1'b0, '0},
        '{REQ_POLL,    1'b0, 8'h00, SIGN_KEEP,    1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_valid;
    logic                 o_ready;
    logic [1:0]           i_req_type;
    logic                 i_traj_busy;
    logic [7:0]           i_sensor_bits;
    logic signed [1:0]    i_corr_sign;
    logic                 o_valid;
    logic                 i_ready;
    logic [1:0]           o_request_code;
    logic [2:0]           o_phase;
    logic                 o_pid_reset;

    // sequencer state as predicted
    t_cfg          seq_cfg;
    logic [2:0]    seq_phase;
    logic [1:0]    seq_request;
    logic [1:0]    steer_dir;
    logic [CW-1:0] lost_ticks;
    logic [CW-1:0] confirm_ticks;
    logic [CW-1:0] brake_left;
    logic [CW-1:0] settle_left;

    t_result     pending_results[$];
    bit          no_gaps;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned phase_hits[5];

    line_loss_recovery_fsm_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_traj_busy    (i_traj_busy),
        .i_sensor_bits  (i_sensor_bits),
        .i_corr_sign    (i_corr_sign),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_request_code (o_request_code),
        .o_phase        (o_phase),
        .o_pid_reset    (o_pid_reset)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // rotate toward the last steering side, right when unknown
    function automatic logic [1:0] turn_request();
        return (steer_dir == DIR_LEFT) ? RQ_LEFT : RQ_RIGHT;
    endfunction

    // advance the predicted sequencer by one item and return its result
    function automatic t_result step_sequencer(input t_stim s);
        t_result r;
        logic    line;
        line = (s.sensor != 8'h00);
        r.pid_reset = 1'b0;
        case (s.req)
            REQ_POLL: begin
                if (!s.traj) begin
                    seq_request = RQ_NONE;
                end else begin
                    if (line) begin
                        lost_ticks = '0;
                    end else if (lost_ticks < seq_cfg.lost_limit && lost_ticks != CNT_MAX) begin
                        lost_ticks++;
                    end
                    case (seq_phase)
                        PH_NORMAL: begin
                            if (lost_ticks >= seq_cfg.lost_threshold) begin
                                seq_request = turn_request();
                                brake_left  = CW'(seq_cfg.brake_ticks);
                                seq_phase   = PH_BRAKE;
                            end
                        end
                        PH_BRAKE: begin
                            if (brake_left != '0) begin
                                brake_left--;
                            end else begin
                                seq_request = turn_request();
                                seq_phase   = PH_ROTATE;
                            end
                        end
                        PH_ROTATE: begin
                            if (line) begin
                                seq_request   = RQ_FOUND;
                                confirm_ticks = CW'(1);
                                seq_phase     = PH_RECOVER;
                            end
                        end
                        PH_RECOVER: begin
                            if (line) begin
                                if (confirm_ticks != CNT_MAX) confirm_ticks++;
                                if (confirm_ticks >= seq_cfg.recover_ticks) begin
                                    r.pid_reset = 1'b1;
                                    seq_request = RQ_NONE;
                                    settle_left = CW'(seq_cfg.stable_ticks);
                                    seq_phase   = PH_STABLE;
                                end
                            end else begin
                                confirm_ticks = '0;
                                seq_request   = turn_request();
                                seq_phase     = PH_ROTATE;
                            end
                        end
                        PH_STABLE: begin
                            if (settle_left != '0) begin
                                settle_left--;
                            end else begin
                                seq_request   = RQ_NONE;
                                lost_ticks    = '0;
                                confirm_ticks = '0;
                                seq_phase     = PH_NORMAL;
                            end
                        end
                        default: seq_phase = PH_NORMAL;
                    endcase
                end
            end
            REQ_DIR: begin
                // any negative pattern means left, zero keeps the old side
                if (s.sign[1]) begin
                    steer_dir = DIR_LEFT;
                end else if (s.sign == SIGN_RIGHT) begin
                    steer_dir = DIR_RIGHT;
                end
            end
            REQ_RESTART: begin
                lost_ticks    = '0;
                confirm_ticks = '0;
                seq_phase     = PH_NORMAL;
                seq_request   = RQ_NONE;
                r.pid_reset   = 1'b1;
            end
            default: ;
        endcase
        r.request_code = seq_request;
        r.phase        = seq_phase;
        return r;
    endfunction

    // random register value, mostly small so that the sequence gets deep
    function automatic logic [CFG_W-1:0] pick_reg();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // present one item after a random gap and record its expected result
    task automatic push_item(input t_stim s);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= s.req;
        i_traj_busy   <= s.traj;
        i_sensor_bits <= s.sensor;
        i_corr_sign   <= s.sign;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (s.typed) begin
            void'(step_sequencer(s));
            pending_results.push_back(s.exp);
        end else begin
            pending_results.push_back(step_sequencer(s));
        end
    endtask

    // stop sending and wait until the block has nothing in flight
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DUT_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
    endtask

    // write the whole register set, block idle
    task automatic load_cfg(input t_cfg c);
        write_reg(CFG_LOST_THRESHOLD, c.lost_threshold);
        write_reg(CFG_LOST_LIMIT, c.lost_limit);
        write_reg(CFG_BRAKE_TICKS, c.brake_ticks);
        write_reg(CFG_RECOVER_TICKS, c.recover_ticks);
        write_reg(CFG_STABLE_TICKS, c.stable_ticks);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        seq_cfg = c;
    endtask

    // result side: random stall before each item, none in calm stretches
    initial begin : result_sink
        int unsigned stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_phase <= PH_STABLE) phase_hits[o_phase]++;
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: code %0d phase %0d pid_reset %0d",
                             o_request_code, o_phase, o_pid_reset);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_request_code !== want.request_code || o_phase !== want.phase ||
                    o_pid_reset !== want.pid_reset) begin
                    if (mismatches < 10)
                        $display("mismatch at result %0d: exp code %0d phase %0d pid_reset %0d, %s",
                                 results_seen, want.request_code, want.phase, want.pid_reset,
                                 $sformatf("got code %0d phase %0d pid_reset %0d",
                                           o_request_code, o_phase, o_pid_reset));
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_wr_en || (i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // reset, directed rows, then random items under several settings
    initial begin : stimulus
        t_stim       s;
        t_cfg        c;
        int unsigned pick;
        int unsigned run_left;
        logic        line_run;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = REQ_POLL;
        i_traj_busy   = 1'b0;
        i_sensor_bits = 8'h00;
        i_corr_sign   = SIGN_KEEP;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_LOST_THRESHOLD;
        i_cfg_wdata   = '0;
        no_gaps       = 1'b0;
        items_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        run_left      = 0;
        line_run      = 1'b0;
        seq_cfg = '{RST_LOST_THRESHOLD, RST_LOST_LIMIT, RST_BRAKE_TICKS,
                    RST_RECOVER_TICKS, RST_STABLE_TICKS};
        seq_phase     = PH_NORMAL;
        seq_request   = RQ_NONE;
        steer_dir     = DIR_UNKNOWN;
        lost_ticks    = '0;
        confirm_ticks = '0;
        brake_left    = '0;
        settle_left   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int k = 0; k < 26; k++) begin
            if (k == SHORT_CFG_ROW) begin
                drain();
                load_cfg(SHORT_CFG);
            end
            push_item(DIRECTED_ROWS[k]);
        end

        // random items, one batch per register setting
        for (int k = 0; k < NUM_SETTINGS; k++) begin
            drain();
            if (k == 0)
                c = '0;
            else if (k == 1)
                c = '1;
            else
                c = '{pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg()};
            load_cfg(c);
            no_gaps = (k % 4 == 3);
            repeat (ITEMS_PER_SETTING) begin
                // runs of lost and seen line, with some noise mixed in
                if (run_left == 0) begin
                    line_run = ~line_run;
                    run_left = $urandom_range(1, 10);
                end
                run_left--;
                s.req    = REQ_POLL;
                s.traj   = 1'b1;
                s.sensor = line_run ? 8'($urandom_range(1, 255)) : 8'h00;
                s.sign   = 2'($urandom);
                s.typed  = 1'b0;
                s.exp    = '0;
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    s.req = REQ_DIR;
                else if (pick < 8)
                    s.req = REQ_RESTART;
                else if (pick < 9)
                    s.req = REQ_UNUSED;
                else if (pick < 13)
                    s.traj = 1'b0;
                if (s.req != REQ_POLL || !s.traj) begin
                    s.traj   = (s.req == REQ_POLL) ? 1'b0 : 1'($urandom);
                    s.sensor = 8'($urandom);
                end
                push_item(s);
            end
        end
        no_gaps = 1'b0;
        drain();

        $display("%0d items over %0d register settings, %0d results checked, %0d mismatches",
                 items_sent, NUM_SETTINGS + 2, results_seen, mismatches);
        $display("results by phase: normal %0d brake %0d rotate %0d recover %0d stable %0d",
                 phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3], phase_hits[4]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
